[rtl/lssi_pkg.sv]
package lssi_pkg;

   // Longest code stream the size report is scaled for
   localparam longint unsigned MAX_CODE_BYTES = 64'd65536;

   localparam int unsigned SIZE_W = 19;
   localparam longint unsigned SIZE_FIELD_MAX = (64'd1 << SIZE_W) - 64'd1;
   localparam longint unsigned SIZE_RAW_LIMIT = MAX_CODE_BYTES * 64'd5;
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = (SIZE_RAW_LIMIT > SIZE_FIELD_MAX) ?
      SIZE_W'(SIZE_FIELD_MAX) : SIZE_W'(SIZE_RAW_LIMIT);

   // Opcode and field codes
   localparam logic [6:0] OP_LOAD     = 7'h03;
   localparam logic [6:0] OP_STORE    = 7'h23;
   localparam logic [1:0] QUAD_LONG   = 2'b11;
   localparam logic [1:0] QUAD_C0     = 2'b00;
   localparam logic [1:0] QUAD_C2     = 2'b10;
   localparam logic [2:0] F3_CLW      = 3'b010;
   localparam logic [2:0] F3_CSW      = 3'b110;
   localparam logic [7:0] NOP_LOW_BYTE = 8'h13;

   // Item counts per instruction in the emitted stream
   localparam logic [3:0] STUB_BYTES  = 4'd8;
   localparam logic [3:0] LONG_BYTES  = 4'd4;
   localparam logic [3:0] SHORT_BYTES = 4'd2;

   // Instruction queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified instruction, or a bare end report
   typedef struct packed {
      logic [31:0] word;
      logic        is_long;
      logic        is_mem;
      logic        last;
      logic        bare;
   } insn_rec_type;

endpackage

[rtl/lssi_if.sv]
interface lssi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_byte;

   modport source (output valid, code_byte, last_byte, input ready);
   modport sink   (input valid, code_byte, last_byte, output ready);
endinterface

interface lssi_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        is_stub_byte;
   logic        last_of_run;
   logic        stream_end;
   logic [18:0] patched_size;

   modport source (output valid, out_byte, byte_valid, is_stub_byte, last_of_run,
                   stream_end, patched_size, input ready);
   modport sink   (input valid, out_byte, byte_valid, is_stub_byte, last_of_run,
                   stream_end, patched_size, output ready);
endinterface

[rtl/lssi_front.sv]
module lssi_front (
   input  logic                  clock,
   input  logic                  reset,
   lssi_req_if.sink              req,
   input  logic                  queue_full,
   output logic                  push_valid,
   output lssi_pkg::insn_rec_type push_rec
);

   logic [23:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        is_long_ff, is_long_in;

   logic        accept;
   logic        long_now;
   logic        complete;
   logic        mem_long;
   logic        mem_short;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Length comes from the first byte, then sticks for the instruction
   assign long_now = (held_count_ff == 2'd0) ? (req.code_byte[1:0] == lssi_pkg::QUAD_LONG)
                                             : is_long_ff;
   assign complete = long_now ? (held_count_ff == 2'd3) : (held_count_ff != 2'd0);

   // Classify loads and stores
   assign mem_long  = (held_bytes_ff[6:0] == lssi_pkg::OP_LOAD) ||
                      (held_bytes_ff[6:0] == lssi_pkg::OP_STORE);
   assign mem_short = ((held_bytes_ff[1:0] == lssi_pkg::QUAD_C0) ||
                       (held_bytes_ff[1:0] == lssi_pkg::QUAD_C2)) &&
                      ((req.code_byte[7:5] == lssi_pkg::F3_CLW) ||
                       (req.code_byte[7:5] == lssi_pkg::F3_CSW));

   // A bare end report carries no instruction, so it never gets a stub
   always_comb begin
      push_rec.word    = long_now ? {req.code_byte, held_bytes_ff}
                                  : {16'h0000, req.code_byte, held_bytes_ff[7:0]};
      push_rec.is_long = long_now;
      push_rec.is_mem  = complete && (long_now ? mem_long : mem_short);
      push_rec.last    = req.last_byte;
      push_rec.bare    = !complete;
      push_valid       = accept && (complete || req.last_byte);
   end

   // Hold partial instruction bytes
   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      is_long_in    = is_long_ff;
      if (accept) begin
         is_long_in = long_now;
         if (complete || req.last_byte) begin
            held_count_in = 2'd0;
         end else begin
            held_count_in = held_count_ff + 2'd1;
            unique case (held_count_ff)
               2'd0:    held_bytes_in[7:0]   = req.code_byte;
               2'd1:    held_bytes_in[15:8]  = req.code_byte;
               default: held_bytes_in[23:16] = req.code_byte;
            endcase
         end
         if (req.last_byte) begin
            is_long_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_bytes_ff <= held_bytes_in;
      if (reset) begin
         held_count_ff <= 2'd0;
         is_long_ff    <= 1'b0;
      end else begin
         held_count_ff <= held_count_in;
         is_long_ff    <= is_long_in;
      end
   end

endmodule

[rtl/lssi_queue.sv]
module lssi_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  lssi_pkg::insn_rec_type push_rec,
   output logic                   full,
   output logic                   head_valid,
   output lssi_pkg::insn_rec_type head_rec,
   input  logic                   pop
);

   lssi_pkg::insn_rec_type entry_ff [lssi_pkg::QUEUE_DEPTH];

   logic [lssi_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lssi_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lssi_pkg::QPTR_W:0]   count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (count_ff == (lssi_pkg::QPTR_W+1)'(lssi_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/lssi_back.sv]
module lssi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  lssi_pkg::insn_rec_type head_rec,
   output logic                   pop,
   lssi_rsp_if.source             rsp
);

   logic [3:0]                  idx_ff, idx_in;
   logic [lssi_pkg::SIZE_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff;
   logic [7:0]                  out_byte_ff;
   logic                        byte_valid_ff;
   logic                        is_stub_ff;
   logic                        last_of_run_ff;
   logic                        stream_end_ff;
   logic [lssi_pkg::SIZE_W-1:0] size_ff;

   logic                        advance;
   logic [3:0]                  stub_n;
   logic [3:0]                  total;
   logic                        final_item;
   logic                        in_stub;
   logic [7:0]                  data_byte;
   logic [7:0]                  cur_byte;
   logic [lssi_pkg::SIZE_W-1:0] count_next;

   assign advance = head_valid && (!rsp_valid_ff || rsp.ready);

   // Work out the current emitted byte of the head instruction
   always_comb begin
      stub_n     = head_rec.is_mem ? lssi_pkg::STUB_BYTES : 4'd0;
      total      = head_rec.bare ? 4'd1 :
                   stub_n + (head_rec.is_long ? lssi_pkg::LONG_BYTES
                                              : lssi_pkg::SHORT_BYTES);
      final_item = (idx_ff == total - 4'd1);
      in_stub    = head_rec.is_mem && (idx_ff < lssi_pkg::STUB_BYTES);
      // Stub length is a multiple of four, so the low bits index the word
      data_byte  = head_rec.word[8*idx_ff[1:0] +: 8];
      if (in_stub) begin
         cur_byte = (idx_ff[1:0] == 2'd0) ? lssi_pkg::NOP_LOW_BYTE : 8'h00;
      end else begin
         cur_byte = data_byte;
      end
      count_next = (count_ff < lssi_pkg::SIZE_LIMIT) ? count_ff + 1'b1 : count_ff;
   end

   assign pop = advance && final_item;

   // Step through the instruction and keep the running size
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (advance) begin
         idx_in = final_item ? 4'd0 : idx_ff + 4'd1;
         if (final_item && head_rec.last) begin
            count_in = '0;
         end else if (!head_rec.bare) begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff    <= head_rec.bare ? 8'h00 : cur_byte;
         byte_valid_ff  <= !head_rec.bare;
         is_stub_ff     <= in_stub;
         last_of_run_ff <= final_item;
         stream_end_ff  <= final_item && head_rec.last;
         size_ff        <= head_rec.bare ? count_ff : count_next;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
         count_ff     <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_byte     = out_byte_ff;
   assign rsp.byte_valid   = byte_valid_ff;
   assign rsp.is_stub_byte = is_stub_ff;
   assign rsp.last_of_run  = last_of_run_ff;
   assign rsp.stream_end   = stream_end_ff;
   assign rsp.patched_size = size_ff;

endmodule

[rtl/riscv_load_store_stub_inserter_unit.sv]
// Load/store stub inserter for an RV32 code stream.
// req channel: one code byte per transaction, little endian, last_byte on
// the final byte of the stream. rsp channel: one rewritten byte per
// transaction; each load or store (long or compressed form) is preceded by
// two NOP words, eight stub bytes, then the original instruction bytes.
// A stream that ends inside an instruction drops it and gives one bare
// report (byte_valid low); stream_end marks the last transaction of a stream
// and patched_size then holds the saturated output size.
// A completing byte is written into the queue at the edge that accepts it;
// its first output byte then goes into the output register that drives rsp.
// Throughput: req takes one byte per cycle while the 4-entry instruction
// queue has room; rsp gives one byte per cycle while the receiver is ready,
// so a load or store gives 10 or 12 bytes and rsp sets the sustained rate.
// When the receiver stalls, the output register holds, the queue fills and
// req.ready drops; no transaction is lost.
// Reset (synchronous) empties the queue, drops partial instructions and
// clears the size count.
module riscv_load_store_stub_inserter_unit (
   input  logic      clock,
   input  logic      reset,
   lssi_req_if.sink  req,
   lssi_rsp_if.source rsp
);

   logic                   push_valid;
   lssi_pkg::insn_rec_type push_rec;
   logic                   queue_full;
   logic                   head_valid;
   lssi_pkg::insn_rec_type head_rec;
   logic                   pop;

   lssi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   lssi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop)
   );

   lssi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
